// File: hw/rtl/resc_pkg.sv
// types, codes and register indexes shared by the radio enable switch controller
// no dependencies; used by resc_cfg_regs, resc_ctrl and the top level
package resc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_COLD  = 2'd1;
    localparam logic [1:0] REQ_WARM  = 2'd2;
    localparam logic [1:0] REQ_FORCE = 2'd3;

    // controller modes
    localparam logic [2:0] MODE_COLD  = 3'd0;
    localparam logic [2:0] MODE_ADV   = 3'd1;
    localparam logic [2:0] MODE_TIMED = 3'd2;
    localparam logic [2:0] MODE_CONN  = 3'd3;
    localparam logic [2:0] MODE_OFF   = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ADVERT   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_LEVEL    = 2'd3;

    localparam logic [TimeW-1:0] DEBOUNCE_RST = 32'd50;
    localparam logic [TimeW-1:0] ADVERT_RST   = 32'd120000;
    localparam logic [TimeW-1:0] HOLD_RST     = 32'd5000;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [TimeW-1:0] now_ms;
        logic             raw_pin;
        logic             client_connected;
    } req_t;

    typedef struct packed {
        logic [2:0] ctrl_state;
        logic       radio_enabled;
        logic       start_radio;
        logic       stop_radio;
        logic       drop_client;
        logic       show_connected;
        logic       show_disconnected;
        logic       switch_pressed;
    } res_t;

    typedef struct packed {
        logic [TimeW-1:0] debounce_ms;
        logic [TimeW-1:0] advert_timeout_ms;
        logic [TimeW-1:0] hold_ms;
        logic             active_level;
    } cfg_t;

endpackage

// File: hw/rtl/resc_cfg_regs.sv
// configuration registers of the radio enable switch controller
// depends on resc_pkg
module resc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [resc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [resc_pkg::CfgDataW-1:0] cfg_data,
    output resc_pkg::cfg_t               cfg
);

    resc_pkg::cfg_t cfg_reg;
    resc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                resc_pkg::CFG_DEBOUNCE: cfg_next.debounce_ms = cfg_data;
                resc_pkg::CFG_ADVERT:   cfg_next.advert_timeout_ms = cfg_data;
                resc_pkg::CFG_HOLD:     cfg_next.hold_ms = cfg_data;
                resc_pkg::CFG_LEVEL:    cfg_next.active_level = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= resc_pkg::DEBOUNCE_RST;
            cfg_reg.advert_timeout_ms <= resc_pkg::ADVERT_RST;
            cfg_reg.hold_ms           <= resc_pkg::HOLD_RST;
            cfg_reg.active_level      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/resc_ctrl.sv
// switch debounce and five-mode radio controller, one transaction per fire
// depends on resc_pkg
module resc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  resc_pkg::req_t item,
    input  resc_pkg::cfg_t cfg,
    output resc_pkg::res_t result
);

    logic [2:0]                 mode_reg, mode_next;
    logic                       radio_on_reg, radio_on_next;
    logic                       last_conn_reg, last_conn_next;
    logic                       last_pressed_reg, last_pressed_next;
    logic                       pressed_reg, pressed_next;
    logic                       last_raw_reg, last_raw_next;
    logic                       settling_reg, settling_next;
    logic [resc_pkg::TimeW-1:0] entry_time_reg, entry_time_next;
    logic [resc_pkg::TimeW-1:0] press_time_reg, press_time_next;
    logic [resc_pkg::TimeW-1:0] settle_start_reg, settle_start_next;

    logic                       pin_pressed;
    logic [resc_pkg::TimeW-1:0] settle_elapsed;
    logic [resc_pkg::TimeW-1:0] entry_elapsed;
    logic [resc_pkg::TimeW-1:0] press_elapsed;
    resc_pkg::res_t             res;

    assign pin_pressed = (item.raw_pin == cfg.active_level);
    assign entry_elapsed = item.now_ms - entry_time_reg;

    always_comb
    begin
        mode_next         = mode_reg;
        radio_on_next     = radio_on_reg;
        last_conn_next    = last_conn_reg;
        last_pressed_next = last_pressed_reg;
        pressed_next      = pressed_reg;
        last_raw_next     = last_raw_reg;
        settling_next     = settling_reg;
        entry_time_next   = entry_time_reg;
        press_time_next   = press_time_reg;
        settle_start_next = settle_start_reg;
        res               = '0;
        settle_elapsed    = '0;
        press_elapsed     = '0;

        case (item.req_type)
            resc_pkg::REQ_COLD, resc_pkg::REQ_WARM:
            begin
                last_raw_next     = pin_pressed;
                pressed_next      = 1'b0;
                last_pressed_next = 1'b0;
                settling_next     = 1'b0;
                settle_start_next = '0;
                press_time_next   = '0;
                last_conn_next    = 1'b0;
                entry_time_next   = item.now_ms;
                if (item.req_type == resc_pkg::REQ_COLD)
                begin
                    radio_on_next  = 1'b0;
                    res.stop_radio = 1'b1;
                    mode_next      = resc_pkg::MODE_COLD;
                end
                else
                begin
                    radio_on_next   = 1'b1;
                    res.start_radio = 1'b1;
                    mode_next       = resc_pkg::MODE_TIMED;
                end
            end
            resc_pkg::REQ_FORCE:
            begin
                radio_on_next         = 1'b0;
                res.stop_radio        = 1'b1;
                res.drop_client       = item.client_connected;
                res.show_disconnected = 1'b1;
                mode_next             = resc_pkg::MODE_OFF;
                entry_time_next       = item.now_ms;
            end
            default:
            begin
                // debounce: any raw change restarts the settle window
                if (pin_pressed != last_raw_reg)
                begin
                    settling_next     = 1'b1;
                    settle_start_next = item.now_ms;
                    last_raw_next     = pin_pressed;
                end
                settle_elapsed = item.now_ms - settle_start_next;
                if (settling_next && (settle_elapsed >= cfg.debounce_ms))
                begin
                    settling_next = 1'b0;
                    pressed_next  = pin_pressed;
                    if (!pressed_reg && pin_pressed)
                        press_time_next = item.now_ms;
                end
                press_elapsed = item.now_ms - press_time_next;

                case (mode_reg)
                    resc_pkg::MODE_COLD:
                    begin
                        if (pressed_next && !last_pressed_reg)
                        begin
                            radio_on_next   = 1'b1;
                            res.start_radio = 1'b1;
                            mode_next       = resc_pkg::MODE_ADV;
                            entry_time_next = item.now_ms;
                        end
                    end
                    resc_pkg::MODE_ADV:
                    begin
                        if (item.client_connected && !last_conn_reg)
                        begin
                            res.show_connected = 1'b1;
                            mode_next          = resc_pkg::MODE_CONN;
                            entry_time_next    = item.now_ms;
                        end
                    end
                    resc_pkg::MODE_TIMED:
                    begin
                        // a connect edge wins over the timeout
                        if (item.client_connected && !last_conn_reg)
                        begin
                            res.show_connected = 1'b1;
                            mode_next          = resc_pkg::MODE_CONN;
                            entry_time_next    = item.now_ms;
                        end
                        else if (entry_elapsed >= cfg.advert_timeout_ms)
                        begin
                            radio_on_next         = 1'b0;
                            res.stop_radio        = 1'b1;
                            res.drop_client       = item.client_connected;
                            res.show_disconnected = 1'b1;
                            mode_next             = resc_pkg::MODE_OFF;
                            entry_time_next       = item.now_ms;
                        end
                    end
                    resc_pkg::MODE_CONN:
                    begin
                        if (!item.client_connected && last_conn_reg)
                        begin
                            res.show_disconnected = 1'b1;
                            mode_next             = resc_pkg::MODE_ADV;
                            entry_time_next       = item.now_ms;
                        end
                    end
                    resc_pkg::MODE_OFF:
                    begin
                        if (pressed_next && (press_elapsed >= cfg.hold_ms))
                        begin
                            radio_on_next   = 1'b1;
                            res.start_radio = 1'b1;
                            mode_next       = resc_pkg::MODE_TIMED;
                            entry_time_next = item.now_ms;
                        end
                    end
                    default:
                    begin
                        mode_next       = resc_pkg::MODE_COLD;
                        entry_time_next = item.now_ms;
                    end
                endcase
                last_conn_next    = item.client_connected;
                last_pressed_next = pressed_next;
            end
        endcase

        res.ctrl_state     = mode_next;
        res.radio_enabled  = radio_on_next;
        res.switch_pressed = pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= resc_pkg::MODE_COLD;
            radio_on_reg     <= 1'b0;
            last_conn_reg    <= 1'b0;
            last_pressed_reg <= 1'b0;
            pressed_reg      <= 1'b0;
            last_raw_reg     <= 1'b0;
            settling_reg     <= 1'b0;
            entry_time_reg   <= '0;
            press_time_reg   <= '0;
            settle_start_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            radio_on_reg     <= radio_on_next;
            last_conn_reg    <= last_conn_next;
            last_pressed_reg <= last_pressed_next;
            pressed_reg      <= pressed_next;
            last_raw_reg     <= last_raw_next;
            settling_reg     <= settling_next;
            entry_time_reg   <= entry_time_next;
            press_time_reg   <= press_time_next;
            settle_start_reg <= settle_start_next;
        end
    end

    assign result = res;

endmodule

// File: hw/rtl/radio_enable_switch_controller.sv
// top level of the radio enable switch controller: input and result registers
// depends on resc_pkg, resc_cfg_regs and resc_ctrl
//
//  channel   valid      stall      payload     direction
//  request   req_valid  req_stall  req (req_t) in
//  result    res_valid  res_stall  res (res_t) out
//  config    cfg_we     -          cfg_index / cfg_data, no read-back
//
// one transaction per cycle sustained while res_stall is low; an accepted request passes
// from the input register through the controller logic into the result register,
// where res_valid rises with the result
// every request gives exactly one result
// reset clears controller state, valid flags and loads register defaults
// a stalled result holds the pipe; the input register still takes one more
// transaction while the result waits
module radio_enable_switch_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  resc_pkg::req_t                req,
    output logic                          res_valid,
    input  logic                          res_stall,
    output resc_pkg::res_t                res,
    input  logic                          cfg_we,
    input  logic [resc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [resc_pkg::CfgDataW-1:0] cfg_data
);

    logic           in_valid_reg, in_valid_next;
    resc_pkg::req_t in_item_reg;
    logic           res_valid_reg, res_valid_next;
    resc_pkg::res_t res_reg;

    logic           advance;
    logic           fire;
    logic           accept;
    resc_pkg::cfg_t cfg;
    resc_pkg::res_t result;

    resc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    resc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance   = !res_valid_reg || !res_stall;
    assign fire      = in_valid_reg && advance;
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign res_valid_next = fire || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= req;
        if (fire)
            res_reg <= result;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a drop of the client only ever comes with a stop
    a_drop_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.drop_client |-> res.stop_radio)
        else $error("drop_client without stop_radio");

    // start and stop pulses agree with the reported radio state
    a_pulse_radio: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.start_radio && res.stop_radio)
                      && (!res.start_radio || res.radio_enabled)
                      && (!res.stop_radio || !res.radio_enabled))
        else $error("radio pulses disagree with radio_enabled");

    // a transaction leaving the input register always lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("result lost after controller step");

    // the input register is never stalled while the result side is free
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid_reg && res_stall && in_valid_reg)
        else $error("request stalled with a free result register");

endmodule
